@@ src/sitd_pkg.sv @@
// shared types and constants for the signed integer to decimal text unit
package sitd_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned CHAR_W  = 6;
	localparam int unsigned ACC_W   = 34;
	localparam int unsigned POS_W   = 4;
	localparam int unsigned DIGITS  = 10;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

	localparam logic [POS_W-1:0] POS_TOP = 4'(DIGITS - 1);

	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} sitd_item_t;

endpackage

@@ src/sitd_value_if.sv @@
// input channel carrying one signed 32-bit value per beat
interface sitd_value_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

@@ src/sitd_char_if.sv @@
// output channel carrying one ascii character per beat
interface sitd_char_if;
	logic       valid;
	logic       ready;
	logic [5:0] character;
	logic       is_last;

	modport source (output valid, output character, output is_last, input ready);
	modport sink (input valid, input character, input is_last, output ready);
endinterface

@@ src/sitd_front.sv @@
// front end: accepts a value, splits it into sign and magnitude for the queue
module sitd_front (
	sitd_value_if.sink            value_ch,
	input  logic                  can_push,
	output logic                  push,
	output sitd_pkg::sitd_item_t  item
);

	logic [sitd_pkg::VALUE_W-1:0] raw;

	always_comb begin
		raw            = value_ch.value;
		value_ch.ready = can_push;
		push           = value_ch.valid && can_push;
		item.neg       = raw[sitd_pkg::VALUE_W-1];
		item.mag       = item.neg ? (~raw + 32'd1) : raw;
	end

endmodule

@@ src/sitd_queue.sv @@
// short fifo between the front end and the character generator
module sitd_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sitd_pkg::sitd_item_t push_item,
	input  logic                 pop,
	output logic                 can_push,
	output logic                 not_empty,
	output sitd_pkg::sitd_item_t head_item
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	sitd_pkg::sitd_item_t entry_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 do_push;
	logic                 do_pop;

	always_comb begin
		can_push  = count_q != CNT_W'(DEPTH);
		not_empty = count_q != '0;
		head_item = entry_q[rd_ptr_q];
		do_push   = push && can_push;
		do_pop    = pop && not_empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ src/sitd_back.sv @@
// back end: walks decimal positions from the top and drives the character register
module sitd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  sitd_pkg::sitd_item_t q_item,
	output logic                 pop,
	sitd_char_if.source          char_ch
);

	localparam logic [sitd_pkg::ACC_W-1:0] POW10 [sitd_pkg::DIGITS] = '{
		34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000,
		34'd1000000, 34'd10000000, 34'd100000000, 34'd1000000000
	};

	logic                          busy_q;
	logic                          sign_q;
	logic                          lead_q;
	logic [sitd_pkg::POS_W-1:0]    pos_q;
	logic [sitd_pkg::VALUE_W-1:0]  mag_q;
	logic                          out_valid_q;
	logic [sitd_pkg::CHAR_W-1:0]   out_char_q;
	logic                          out_last_q;

	logic [sitd_pkg::ACC_W-1:0]    pw;
	logic [sitd_pkg::ACC_W-1:0]    cand [10];
	logic [sitd_pkg::ACC_W-1:0]    acc;
	logic [sitd_pkg::ACC_W-1:0]    sub;
	logic [3:0]                    digit;
	logic                          can_load;
	logic                          zero_lead;
	logic                          emit_now;
	logic                          step;
	logic                          load;

	always_comb begin
		pw    = POW10[pos_q];
		acc   = {2'b00, mag_q};
		digit = '0;
		sub   = '0;
		for (int k = 0; k < 10; k++) begin
			cand[k] = pw * 34'(k);
		end
		for (int k = 1; k < 10; k++) begin
			if (acc >= cand[k]) begin
				digit = 4'(k);
				sub   = cand[k];
			end
		end
		can_load  = !out_valid_q || char_ch.ready;
		zero_lead = lead_q && (digit == '0) && (pos_q != '0);
		emit_now  = busy_q && can_load && (sign_q || !zero_lead);
		step      = busy_q && (sign_q ? can_load : (zero_lead || can_load));
		load      = !busy_q && q_valid;
		pop       = load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			sign_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				sign_q <= q_item.neg;
			end else if (step) begin
				if (sign_q) begin
					sign_q <= 1'b0;
				end else if (!zero_lead && (pos_q == '0)) begin
					busy_q <= 1'b0;
				end
			end
			if (can_load) begin
				out_valid_q <= emit_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mag_q  <= q_item.mag;
			pos_q  <= sitd_pkg::POS_TOP;
			lead_q <= 1'b1;
		end else if (step && !sign_q) begin
			if (!zero_lead) begin
				mag_q  <= mag_q - sub[sitd_pkg::VALUE_W-1:0];
				lead_q <= 1'b0;
			end
			if (pos_q != '0) begin
				pos_q <= pos_q - 1'b1;
			end
		end
		if (emit_now) begin
			out_char_q <= sign_q ? sitd_pkg::CH_MINUS : (sitd_pkg::CH_ZERO + 6'(digit));
			out_last_q <= !sign_q && (pos_q == '0);
		end
	end

	always_comb begin
		char_ch.valid     = out_valid_q;
		char_ch.character = out_char_q;
		char_ch.is_last   = out_last_q;
	end

endmodule

@@ src/signed_int_to_decimal_ascii_unit.sv @@
// top level: signed 32-bit integer to decimal ascii character stream
// first character: the input beat is written into the queue, loaded by the back end, then
// registered for output; skipped leading zero positions and output stalls delay it further
// throughput, while the output is ready: one character per cycle in a run; after a load step
// and a sign step if negative, the back end visits all ten decimal positions, one per cycle
// the input queue takes up to QUEUE_DEPTH values while a run is still being sent
// reset: arst_n clears the queue pointers, the back end busy flags and the output valid
module signed_int_to_decimal_ascii_unit #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	sitd_value_if.sink  value_ch,
	sitd_char_if.source char_ch
);

	sitd_pkg::sitd_item_t front_item;
	sitd_pkg::sitd_item_t head_item;
	logic                 can_push;
	logic                 push;
	logic                 not_empty;
	logic                 pop;

	sitd_front u_front (
		.value_ch (value_ch),
		.can_push (can_push),
		.push     (push),
		.item     (front_item)
	);

	sitd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.can_push  (can_push),
		.not_empty (not_empty),
		.head_item (head_item)
	);

	sitd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (not_empty),
		.q_item  (head_item),
		.pop     (pop),
		.char_ch (char_ch)
	);

	// minus sign only ever opens a run
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(char_ch.valid && (char_ch.character == sitd_pkg::CH_MINUS)) |-> !char_ch.is_last)
		else $error("minus sign flagged as last character");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		char_ch.valid |-> ((char_ch.character == sitd_pkg::CH_MINUS) ||
			((char_ch.character >= sitd_pkg::CH_ZERO) &&
			 (char_ch.character <= (sitd_pkg::CH_ZERO + 6'd9)))))
		else $error("character outside sign and digit codes");

	a_minus_then_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(char_ch.valid && char_ch.ready && (char_ch.character == sitd_pkg::CH_MINUS))
		|=> !(char_ch.valid && (char_ch.character == sitd_pkg::CH_MINUS)))
		else $error("two minus signs in a row");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("back end took an item from an empty queue");

endmodule
